// ===== sv/cau_pkg.sv =====
// Shared definitions for the complex arithmetic unit.
// Opcodes, status codes, register map and the control bundle that rides the divider pipe.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int CAU_DATA_WIDTH = 16;
  localparam int CAU_ADDR_W     = 3;
  localparam int CAU_APB_W      = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // register select is paddr bit 2
  localparam logic REG_SCALAR_RE = 1'b0;
  localparam logic REG_SCALAR_IM = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic       neg_re;
    logic       neg_im;
    logic       ovf_re;
    logic       ovf_im;
    logic       dz;
  } cau_ctl_t;

endpackage

`default_nettype wire

// ===== sv/complex_arithmetic_unit.sv =====
// Complex add/subtract/multiply/divide on signed fixed-point pairs, saturating.
// Top level: front pipeline, divider chain of cau_div_stage, output stage. Uses cau_pkg.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------------------
//   in      | in_valid  | in_stall  | in_opcode in_use_scalar in_a_re/im in_b_re/im
//   out     | out_valid | out_stall | out_res_re out_res_im out_status
//   config  | psel/penable/pwrite   | paddr pwdata prdata (pready tied high)
//
// One request per cycle while the output is not stalled; the divider chain resolves one
// quotient bit per stage for divides, and other opcodes pass through it untouched.
// Reset (synchronous, rst_n low) empties the pipe and clears the scalar registers.
// Each stage holds while the next one is full and stalled, so bubbles are squeezed out
// and a new request is taken while a result waits at the output.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = CAU_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic                          in_use_scalar,
  input  wire logic signed [DATA_WIDTH-1:0]  in_a_re,
  input  wire logic signed [DATA_WIDTH-1:0]  in_a_im,
  input  wire logic signed [DATA_WIDTH-1:0]  in_b_re,
  input  wire logic signed [DATA_WIDTH-1:0]  in_b_im,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]       out_res_re,
  output logic signed [DATA_WIDTH-1:0]       out_res_im,
  output logic [1:0]                         out_status,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [CAU_ADDR_W-1:0]         paddr,
  input  wire logic [CAU_APB_W-1:0]          pwdata,
  output logic [CAU_APB_W-1:0]               prdata,
  output logic                               pready
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = W - 1;
  localparam int NW   = 2 * W + 1;
  localparam int QW   = W + 1;
  localparam int NDIV = W + 1;

  // ---------------- configuration ----------------
  logic signed [W-1:0] scal_re_r, scal_im_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scal_re_r <= '0;
      scal_im_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SCALAR_IM) begin
        scal_im_r <= pwdata[W-1:0];
      end else begin
        scal_re_r <= pwdata[W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SCALAR_IM) ? CAU_APB_W'(scal_im_r)
                                              : CAU_APB_W'(scal_re_r);

  // ---------------- stage 1: operand capture ----------------
  logic                s1_v_r, s1_stall, s2_stall;
  logic [1:0]          s1_op_r;
  logic signed [W-1:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  assign s1_stall = s1_v_r && s2_stall;
  assign in_stall = s1_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!s1_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_stall && in_valid) begin
      s1_op_r <= in_opcode;
      s1_ar_r <= in_a_re;
      s1_ai_r <= in_a_im;
      s1_br_r <= in_use_scalar ? scal_re_r : in_b_re;
      s1_bi_r <= in_use_scalar ? scal_im_r : in_b_im;
    end
  end

  // ---------------- stage 2: products and plain sums ----------------
  logic                  s2_v_r, s3_stall, s2_dz_r;
  logic [1:0]            s2_op_r;
  logic signed [2*W-1:0] s2_prr_r, s2_pii_r, s2_pir_r, s2_pri_r, s2_sqr_r, s2_sqi_r;
  logic signed [W:0]     s2_asr_r, s2_asi_r, s2_asr_nxt, s2_asi_nxt;

  assign s2_stall = s2_v_r && s3_stall;

  always_comb begin
    if (s1_op_r == OP_SUB) begin
      s2_asr_nxt = (W+1)'(s1_ar_r) - (W+1)'(s1_br_r);
      s2_asi_nxt = (W+1)'(s1_ai_r) - (W+1)'(s1_bi_r);
    end else begin
      s2_asr_nxt = (W+1)'(s1_ar_r) + (W+1)'(s1_br_r);
      s2_asi_nxt = (W+1)'(s1_ai_r) + (W+1)'(s1_bi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (!s2_stall) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s2_stall && s1_v_r) begin
      s2_op_r  <= s1_op_r;
      s2_prr_r <= s1_ar_r * s1_br_r;
      s2_pii_r <= s1_ai_r * s1_bi_r;
      s2_pir_r <= s1_ai_r * s1_br_r;
      s2_pri_r <= s1_ar_r * s1_bi_r;
      s2_sqr_r <= s1_br_r * s1_br_r;
      s2_sqi_r <= s1_bi_r * s1_bi_r;
      s2_asr_r <= s2_asr_nxt;
      s2_asi_r <= s2_asi_nxt;
      s2_dz_r  <= (s1_br_r == '0) && (s1_bi_r == '0);
    end
  end

  // ---------------- stage 3: numerators and |b|^2 ----------------
  logic                 s3_v_r, s4_stall, s3_dz_r;
  logic [1:0]           s3_op_r;
  logic signed [NW-1:0] s3_nre_r, s3_nim_r, s3_nre_nxt, s3_nim_nxt;
  logic [NW-1:0]        s3_den_r;

  assign s3_stall = s3_v_r && s4_stall;

  always_comb begin
    unique case (s2_op_r)
      OP_ADD, OP_SUB: begin
        s3_nre_nxt = NW'(s2_asr_r);
        s3_nim_nxt = NW'(s2_asi_r);
      end
      OP_MUL: begin
        s3_nre_nxt = NW'(s2_prr_r) - NW'(s2_pii_r);
        s3_nim_nxt = NW'(s2_pir_r) + NW'(s2_pri_r);
      end
      default: begin // OP_DIV: a * conj(b)
        s3_nre_nxt = NW'(s2_prr_r) + NW'(s2_pii_r);
        s3_nim_nxt = NW'(s2_pir_r) - NW'(s2_pri_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (!s3_stall) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s3_stall && s2_v_r) begin
      s3_op_r  <= s2_op_r;
      s3_dz_r  <= s2_dz_r;
      s3_nre_r <= s3_nre_nxt;
      s3_nim_r <= s3_nim_nxt;
      s3_den_r <= NW'($unsigned(s2_sqr_r)) + NW'($unsigned(s2_sqi_r));
    end
  end

  // ---------------- stage 4: sign / magnitude ----------------
  logic          s4_v_r, s5_stall, s4_dz_r, s4_nre_r, s4_nim_r;
  logic [1:0]    s4_op_r;
  logic [NW-1:0] s4_mre_r, s4_mim_r, s4_den_r;

  assign s4_stall = s4_v_r && s5_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (!s4_stall) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s4_stall && s3_v_r) begin
      s4_op_r  <= s3_op_r;
      s4_dz_r  <= s3_dz_r;
      s4_den_r <= s3_den_r;
      s4_nre_r <= s3_nre_r[NW-1];
      s4_nim_r <= s3_nim_r[NW-1];
      s4_mre_r <= s3_nre_r[NW-1] ? NW'(-s3_nre_r) : NW'(s3_nre_r);
      s4_mim_r <= s3_nim_r[NW-1] ? NW'(-s3_nim_r) : NW'(s3_nim_r);
    end
  end

  // ---------------- stage 5: product rounding ----------------
  logic          s5_v_r, s5_dz_r, s5_nre_r, s5_nim_r;
  logic [1:0]    s5_op_r;
  logic [NW-1:0] s5_mre_r, s5_mim_r, s5_den_r, s5_mre_nxt, s5_mim_nxt;
  logic [NW-1:0] rnd_half;

  assign rnd_half = NW'(1) << (F - 1);

  always_comb begin
    if (s4_op_r == OP_MUL) begin
      // round half away from zero on the magnitude
      s5_mre_nxt = (s4_mre_r + rnd_half) >> F;
      s5_mim_nxt = (s4_mim_r + rnd_half) >> F;
    end else begin
      s5_mre_nxt = s4_mre_r;
      s5_mim_nxt = s4_mim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (!s5_stall) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s5_stall && s4_v_r) begin
      s5_op_r  <= s4_op_r;
      s5_dz_r  <= s4_dz_r;
      s5_den_r <= s4_den_r;
      s5_nre_r <= s4_nre_r;
      s5_nim_r <= s4_nim_r;
      s5_mre_r <= s5_mre_nxt;
      s5_mim_r <= s5_mim_nxt;
    end
  end

  // ---------------- divider chain ----------------
  logic          d_v   [0:NDIV];
  logic          d_stl [0:NDIV];
  cau_ctl_t      d_ctl [0:NDIV];
  logic [NW-1:0] d_rre [0:NDIV];
  logic [NW-1:0] d_rim [0:NDIV];
  logic [NW-1:0] d_den [0:NDIV];
  logic [QW-1:0] d_qre [0:NDIV];
  logic [QW-1:0] d_qim [0:NDIV];

  assign s5_stall = s5_v_r && d_stl[0];
  assign d_v[0]   = s5_v_r;
  assign d_ctl[0] = '{op: s5_op_r, neg_re: s5_nre_r, neg_im: s5_nim_r,
                      ovf_re: 1'b0, ovf_im: 1'b0, dz: s5_dz_r};
  assign d_rre[0] = s5_mre_r;
  assign d_rim[0] = s5_mim_r;
  assign d_den[0] = s5_den_r;
  assign d_qre[0] = '0;
  assign d_qim[0] = '0;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    cau_div_stage #(
      .DATA_WIDTH (W),
      .FIRST      (g == 0)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (d_v[g]),
      .up_stall  (d_stl[g]),
      .up_ctl    (d_ctl[g]),
      .up_rem_re (d_rre[g]),
      .up_rem_im (d_rim[g]),
      .up_den    (d_den[g]),
      .up_q_re   (d_qre[g]),
      .up_q_im   (d_qim[g]),
      .dn_valid  (d_v[g+1]),
      .dn_stall  (d_stl[g+1]),
      .dn_ctl    (d_ctl[g+1]),
      .dn_rem_re (d_rre[g+1]),
      .dn_rem_im (d_rim[g+1]),
      .dn_den    (d_den[g+1]),
      .dn_q_re   (d_qre[g+1]),
      .dn_q_im   (d_qim[g+1])
    );
  end

  // ---------------- output stage: quotient rounding and saturation ----------------
  logic                out_valid_r;
  logic signed [W-1:0] res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  logic [1:0]          status_r, status_nxt;
  cau_ctl_t            f_ctl;
  logic [NW-1:0]       f_mre, f_mim, lim_pos, lim_neg, big;
  logic [W:0]          pk_re, pk_im;

  function automatic logic [W:0] sat_pack(input logic neg, input logic [NW-1:0] mag);
    logic          n;
    logic [NW-1:0] lim;
    logic [NW-1:0] m;
    logic          clip;
    n    = neg && (mag != '0);
    lim  = n ? (NW'(1) << F) : ((NW'(1) << F) - NW'(1));
    clip = (mag > lim);
    m    = clip ? lim : mag;
    return {clip, (n ? (-m[W-1:0]) : m[W-1:0])};
  endfunction

  assign d_stl[NDIV] = out_valid_r && out_stall;
  assign f_ctl       = d_ctl[NDIV];
  assign lim_pos     = (NW'(1) << F) - NW'(1);
  assign lim_neg     = NW'(1) << F;
  assign big         = NW'(1) << W;

  always_comb begin
    if (f_ctl.op == OP_DIV) begin
      f_mre = f_ctl.ovf_re ? big : ((NW'(d_qre[NDIV]) + NW'(1)) >> 1);
      f_mim = f_ctl.ovf_im ? big : ((NW'(d_qim[NDIV]) + NW'(1)) >> 1);
    end else begin
      f_mre = d_rre[NDIV];
      f_mim = d_rim[NDIV];
    end
    pk_re = sat_pack(f_ctl.neg_re, f_mre);
    pk_im = sat_pack(f_ctl.neg_im, f_mim);
    if (f_ctl.op == OP_DIV && f_ctl.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      status_nxt = ST_DZ;
    end else begin
      res_re_nxt = pk_re[W-1:0];
      res_im_nxt = pk_im[W-1:0];
      status_nxt = (pk_re[W] || pk_im[W]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!d_stl[NDIV]) begin
      out_valid_r <= d_v[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (!d_stl[NDIV] && d_v[NDIV]) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = res_re_r;
  assign out_res_im = res_im_r;
  assign out_status = status_r;

  // ---------------- assertions ----------------
  a_stall_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DZ) |-> (out_res_re == '0 && out_res_im == '0))
    else $error("divide-by-zero result not zero");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_SAT || out_status == ST_DZ))
    else $error("bad status code");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SAT) |->
      (out_res_re == W'(lim_pos) || out_res_re == W'(lim_neg) ||
       out_res_im == W'(lim_pos) || out_res_im == W'(lim_neg)))
    else $error("saturation flagged but no part at a limit");

endmodule

`default_nettype wire

// ===== sv/cau_div_stage.sv =====
// One registered step of the restoring divider: one quotient bit for each part.
// Non-divide requests pass through untouched. Uses cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_div_stage import cau_pkg::*; #(
  parameter int DATA_WIDTH = CAU_DATA_WIDTH,
  parameter bit FIRST      = 1'b0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    up_valid,
  output logic                         up_stall,
  input  wire cau_ctl_t                up_ctl,
  input  wire logic [2*DATA_WIDTH:0]   up_rem_re,
  input  wire logic [2*DATA_WIDTH:0]   up_rem_im,
  input  wire logic [2*DATA_WIDTH:0]   up_den,
  input  wire logic [DATA_WIDTH:0]     up_q_re,
  input  wire logic [DATA_WIDTH:0]     up_q_im,
  output logic                         dn_valid,
  input  wire logic                    dn_stall,
  output cau_ctl_t                     dn_ctl,
  output logic [2*DATA_WIDTH:0]        dn_rem_re,
  output logic [2*DATA_WIDTH:0]        dn_rem_im,
  output logic [2*DATA_WIDTH:0]        dn_den,
  output logic [DATA_WIDTH:0]          dn_q_re,
  output logic [DATA_WIDTH:0]          dn_q_im
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2 * W + 1;
  localparam int QW = W + 1;

  logic            v_r;
  cau_ctl_t        ctl_r, ctl_nxt;
  logic [NW-1:0]   rem_re_r, rem_im_r, den_r;
  logic [NW-1:0]   rem_re_nxt, rem_im_nxt;
  logic [QW-1:0]   q_re_r, q_im_r, q_re_nxt, q_im_nxt;
  logic [NW-1:0]   sh_re, sh_im;
  logic            bit_re, bit_im;

  assign up_stall = v_r && dn_stall;

  always_comb begin
    sh_re  = (FIRST) ? up_rem_re : (up_rem_re << 1);
    sh_im  = (FIRST) ? up_rem_im : (up_rem_im << 1);
    bit_re = (sh_re >= up_den);
    bit_im = (sh_im >= up_den);
    ctl_nxt    = up_ctl;
    rem_re_nxt = up_rem_re;
    rem_im_nxt = up_rem_im;
    q_re_nxt   = up_q_re;
    q_im_nxt   = up_q_im;
    if (up_ctl.op == OP_DIV) begin
      rem_re_nxt = bit_re ? (sh_re - up_den) : sh_re;
      rem_im_nxt = bit_im ? (sh_im - up_den) : sh_im;
      q_re_nxt   = {up_q_re[QW-2:0], bit_re};
      q_im_nxt   = {up_q_im[QW-2:0], bit_im};
      // quotient of two or more cannot fit: flag it on the integer step
      if (FIRST) begin
        ctl_nxt.ovf_re = (up_rem_re >= (up_den << 1));
        ctl_nxt.ovf_im = (up_rem_im >= (up_den << 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!up_stall) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      ctl_r    <= ctl_nxt;
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      den_r    <= up_den;
      q_re_r   <= q_re_nxt;
      q_im_r   <= q_im_nxt;
    end
  end

  assign dn_valid  = v_r;
  assign dn_ctl    = ctl_r;
  assign dn_rem_re = rem_re_r;
  assign dn_rem_im = rem_im_r;
  assign dn_den    = den_r;
  assign dn_q_re   = q_re_r;
  assign dn_q_im   = q_im_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for complex_arithmetic_unit: add, subtract, multiply and divide
// on Q1.15 pairs, scalar operand registers, saturation and divide-by-zero flags.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps

import cau_pkg::*;

typedef struct {
  logic signed [15:0] re;
  logic signed [15:0] im;
  logic [1:0]         st;
} cplx_result_t;

class cplx_scoreboard;
  cplx_result_t expected_q[$];
  logic signed [15:0] scal_re = 0;
  logic signed [15:0] scal_im = 0;
  int errors = 0;
  int checked = 0;
  int op_count[4] = '{0, 0, 0, 0};

  // magnitude sum of two signed terms given as sign and magnitude
  static function longint unsigned signed_sum(bit n1, longint unsigned m1, bit n2,
                                              longint unsigned m2, output bit neg);
    longint unsigned m;
    if (n1 == n2) begin
      m = m1 + m2;
      neg = n1;
    end else if (m1 >= m2) begin
      m = m1 - m2;
      neg = n1;
    end else begin
      m = m2 - m1;
      neg = n2;
    end
    if (m == 0) neg = 0;
    return m;
  endfunction

  static function longint unsigned mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  static function longint unsigned mag_product(longint x, longint y, output bit neg);
    neg = ((x < 0) != (y < 0)) && x != 0 && y != 0;
    return mag(x) * mag(y);
  endfunction

  // round(n * 2^15 / d), anything at or above 2 comes back as just over the limit
  static function longint unsigned fix_quotient(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (q > 1) return 64'd32769;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  static function logic [15:0] clip_word(bit neg, longint unsigned m, inout bit clipped);
    longint unsigned lim;
    lim = neg ? 32768 : 32767;
    if (m > lim) begin
      m = lim;
      clipped = 1;
    end
    return neg ? 16'(-m) : 16'(m);
  endfunction

  function void set_scalar(bit im_sel, logic [15:0] v);
    if (im_sel) scal_im = v;
    else scal_re = v;
  endfunction

  function void note_request(logic [1:0] op, logic use_scal, logic signed [15:0] a_re,
                             logic signed [15:0] a_im, logic signed [15:0] b_re,
                             logic signed [15:0] b_im);
    longint ar, ai, br, bi;
    longint unsigned m1, m2, mr, mi, den;
    bit n1, n2, nr, ni, flip, clip;
    cplx_result_t r;
    ar = a_re;
    ai = a_im;
    br = use_scal ? scal_re : b_re;
    bi = use_scal ? scal_im : b_im;
    clip = 0;
    op_count[op]++;
    if (op == OP_ADD || op == OP_SUB) begin
      flip = (op == OP_SUB);
      mr = signed_sum(ar < 0, mag(ar), ((br < 0) != flip) && br != 0, mag(br), nr);
      mi = signed_sum(ai < 0, mag(ai), ((bi < 0) != flip) && bi != 0, mag(bi), ni);
    end else if (op == OP_MUL) begin
      m1 = mag_product(ar, br, n1);
      m2 = mag_product(ai, bi, n2);
      mr = (signed_sum(n1, m1, !n2 && m2 != 0, m2, nr) + 64'd16384) >> 15;
      m1 = mag_product(ai, br, n1);
      m2 = mag_product(ar, bi, n2);
      mi = (signed_sum(n1, m1, n2, m2, ni) + 64'd16384) >> 15;
    end else begin
      den = mag(br) * mag(br) + mag(bi) * mag(bi);
      if (den == 0) begin
        r.re = 0;
        r.im = 0;
        r.st = ST_DZ;
        expected_q.push_back(r);
        return;
      end
      m1 = mag_product(ar, br, n1);
      m2 = mag_product(ai, bi, n2);
      mr = fix_quotient(signed_sum(n1, m1, n2, m2, nr), den);
      m1 = mag_product(ai, br, n1);
      m2 = mag_product(ar, bi, n2);
      mi = fix_quotient(signed_sum(n1, m1, !n2 && m2 != 0, m2, ni), den);
    end
    if (mr == 0) nr = 0;
    if (mi == 0) ni = 0;
    r.re = clip_word(nr, mr, clip);
    r.im = clip_word(ni, mi, clip);
    r.st = clip ? ST_SAT : ST_OK;
    expected_q.push_back(r);
  endfunction

  function void check_result(logic signed [15:0] re, logic signed [15:0] im,
                             logic [1:0] st);
    cplx_result_t e;
    if (expected_q.size() == 0) begin
      $error("result with nothing expected: re=%0d im=%0d status=%0d", re, im, st);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (re !== e.re) begin
      $error("res_re: expected %0d, got %0d", e.re, re);
      errors++;
    end
    if (im !== e.im) begin
      $error("res_im: expected %0d, got %0d", e.im, im);
      errors++;
    end
    if (st !== e.st) begin
      $error("status: expected %0d, got %0d", e.st, st);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int LATENCY = 23;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_opcode = OP_ADD;
  logic in_use_scalar = 0;
  logic signed [15:0] in_a_re = 0, in_a_im = 0, in_b_re = 0, in_b_im = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_res_re, out_res_im;
  logic [1:0] out_status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CAU_ADDR_W-1:0] paddr = 0;
  logic [CAU_APB_W-1:0] pwdata = 0;
  logic [CAU_APB_W-1:0] prdata;
  logic pready;

  cplx_scoreboard sb = new();
  bit quiet = 0;
  int long_hold = 0;
  int n_cfg = 0;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_use_scalar(in_use_scalar), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall), .out_res_re(out_res_re),
    .out_res_im(out_res_im), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_res_re, out_res_im, out_status);

  // receiver: a long hold-off on request, otherwise random stall bursts unless quiet is set
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall = 1;
        long_hold--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_stall = 1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall = 0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [1:0] op, logic us, logic [15:0] ar, logic [15:0] ai,
                           logic [15:0] br, logic [15:0] bi);
    in_valid = 1;
    in_opcode = op;
    in_use_scalar = us;
    in_a_re = ar;
    in_a_im = ai;
    in_b_re = br;
    in_b_im = bi;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, us, ar, ai, br, bi);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_scalar(logic sel, logic [15:0] v);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {sel, 2'b00};
    pwdata = {{16{v[15]}}, v};
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    sb.set_scalar(sel, v);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    n_cfg++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++)
      send_item(2'($urandom_range(0, 3)), ($urandom_range(0, 3) == 0),
                pick_word(), pick_word(), pick_word(), pick_word());
  endtask

  initial begin
    logic [15:0] sre[5] = '{16'h7fff, 16'h8000, 16'h4000, 16'h0000, 16'h0123};
    logic [15:0] sim[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'hc000};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: extremes, every opcode, scalar path at reset values
    send_item(OP_ADD, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_item(OP_ADD, 0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_item(OP_SUB, 0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(OP_SUB, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_MUL, 0, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
    send_item(OP_MUL, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_MUL, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(OP_MUL, 0, 16'h0001, 16'h0000, 16'h4000, 16'h0000);
    send_item(OP_DIV, 0, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    send_item(OP_DIV, 0, 16'h2000, 16'h1000, 16'h4000, 16'h0000);
    send_item(OP_DIV, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_DIV, 0, 16'h7fff, 16'h7fff, 16'h0001, 16'hffff);
    send_item(OP_DIV, 0, 16'h0100, 16'hff00, 16'h7fff, 16'h7fff);
    send_item(OP_DIV, 1, 16'h4000, 16'h4000, 16'h1111, 16'h2222);
    send_item(OP_MUL, 1, 16'h7fff, 16'h7fff, 16'h1111, 16'h2222);
    send_item(OP_ADD, 1, 16'h0005, 16'hfffb, 16'h7fff, 16'h7fff);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_scalar(REG_SCALAR_RE, sre[p]);
      write_scalar(REG_SCALAR_IM, sim[p]);
      send_item(OP_DIV, 1, 16'h3000, 16'hd000, 16'h0, 16'h0);
      send_item(OP_SUB, 1, 16'h8000, 16'h7fff, 16'h0, 16'h0);
      if (p == 1) begin
        long_hold = 300;
        random_items(150);
      end
      random_items(240);
      if (p == 2) begin
        drain(); // sender waits for every result mid-phase
        random_items(60);
      end
      if (p == 4) begin
        quiet = 1;
        random_items(120);
      end
      drain();
    end

    $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d; %0d scalar writes.",
             sb.checked, sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3],
             n_cfg);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
